@@ rtl/bdqs_pkg.sv @@
`default_nettype none

package bdqs_pkg;

  // operation codes carried by a request
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_SEARCH     = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

`default_nettype wire

@@ rtl/bounded_deque_with_search_core.sv @@
// channel   | valid     | stall     | payload
// ----------+-----------+-----------+--------------------------------
// request   | req_valid | req_stall | mode[2:0], value[31:0] signed
// result    | res_valid | res_stall | status[1:0], position[3:0],
//           |           |           | occupancy[4:0]
//
// push, pop, unused codes and a search of an empty store finish in the cycle
// they are taken; the result register loads at that edge.
// any other search loads its result at the end of a scan: the entry memory has
// one read port with a registered read, and the scan reads one entry a cycle
// from the front until the first match or the last entry.
// one request is in work at a time; a new request is taken once the result
// register is empty or is being drained in the same cycle.
// reset clears the front pointer, the count and the result register; the
// entry memory is not cleared, only written entries are ever read.
`default_nettype none

module bounded_deque_with_search_core #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic [2:0]         mode,
  input  wire logic signed [31:0] value,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic [1:0]              status,
  output logic [3:0]              position,
  output logic [4:0]              occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  bdqs_pkg::state_t state;

  logic [AW-1:0] front;
  logic [CW-1:0] count;

  // entry store
  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data;
  logic        rd_valid;

  // scan control
  logic [31:0]   key;
  logic [AW-1:0] scan_ptr;
  logic [CW-1:0] issue_cnt;
  logic [CW-1:0] cmp_idx;

  logic          req_fire;
  logic          is_push;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] front_prev;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] back_addr;
  logic [AW:0]   back_sum;
  logic [AW-1:0] scan_inc;

  // fit a count into the fixed output widths (low bits kept)
  function automatic logic [4:0] occ_bits(input logic [CW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[4:0];
  endfunction

  function automatic logic [3:0] pos_bits(input logic [CW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[3:0];
  endfunction

  // handshake
  assign req_stall = !((state == bdqs_pkg::S_IDLE) && (!res_valid || !res_stall));
  assign req_fire  = req_valid && !req_stall;

  // ring address arithmetic, one compare each
  assign front_prev = (front == '0) ? LAST : front - AW'(1);
  assign front_inc  = (front == LAST) ? '0 : front + AW'(1);
  assign scan_inc   = (scan_ptr == LAST) ? '0 : scan_ptr + AW'(1);
  assign back_sum   = (AW + 1)'(front) + (AW + 1)'(count);
  assign back_addr  = (back_sum >= (AW + 1)'(DEPTH)) ? AW'(back_sum - (AW + 1)'(DEPTH))
                                                     : back_sum[AW-1:0];

  // memory port control
  assign is_push   = mode inside {bdqs_pkg::MODE_PUSH_FRONT, bdqs_pkg::MODE_PUSH_BACK};
  assign mem_we    = req_fire && is_push && (count != FULL);
  assign mem_waddr = (mode == bdqs_pkg::MODE_PUSH_FRONT) ? front_prev : back_addr;
  assign mem_re    = (state == bdqs_pkg::S_SCAN) && (issue_cnt != count);

  // entry memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= value;
    end
    if (mem_re) begin
      rd_data <= mem[scan_ptr];
    end
  end

  // controller and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bdqs_pkg::S_IDLE;
      front     <= '0;
      count     <= '0;
      res_valid <= 1'b0;
      rd_valid  <= 1'b0;
      issue_cnt <= '0;
      cmp_idx   <= '0;
    end else begin
      // result drains unless a new request reloads it
      if (res_valid && !res_stall && !req_fire) begin
        res_valid <= 1'b0;
      end
      case (state)
        bdqs_pkg::S_IDLE: begin
          if (req_fire) begin
            position <= '0;
            case (mode)
              bdqs_pkg::MODE_PUSH_FRONT: begin
                res_valid <= 1'b1;
                if (count == FULL) begin
                  status    <= bdqs_pkg::ST_FULL;
                  occupancy <= occ_bits(count);
                end else begin
                  front     <= front_prev;
                  count     <= count + CW'(1);
                  status    <= bdqs_pkg::ST_OK;
                  occupancy <= occ_bits(count + CW'(1));
                end
              end
              bdqs_pkg::MODE_PUSH_BACK: begin
                res_valid <= 1'b1;
                if (count == FULL) begin
                  status    <= bdqs_pkg::ST_FULL;
                  occupancy <= occ_bits(count);
                end else begin
                  count     <= count + CW'(1);
                  status    <= bdqs_pkg::ST_OK;
                  occupancy <= occ_bits(count + CW'(1));
                end
              end
              bdqs_pkg::MODE_POP_FRONT: begin
                res_valid <= 1'b1;
                if (count == '0) begin
                  status    <= bdqs_pkg::ST_EMPTY;
                  occupancy <= occ_bits(count);
                end else begin
                  front     <= front_inc;
                  count     <= count - CW'(1);
                  status    <= bdqs_pkg::ST_OK;
                  occupancy <= occ_bits(count - CW'(1));
                end
              end
              bdqs_pkg::MODE_POP_BACK: begin
                res_valid <= 1'b1;
                if (count == '0) begin
                  status    <= bdqs_pkg::ST_EMPTY;
                  occupancy <= occ_bits(count);
                end else begin
                  count     <= count - CW'(1);
                  status    <= bdqs_pkg::ST_OK;
                  occupancy <= occ_bits(count - CW'(1));
                end
              end
              bdqs_pkg::MODE_SEARCH: begin
                occupancy <= occ_bits(count);
                if (count == '0) begin
                  res_valid <= 1'b1;
                  status    <= bdqs_pkg::ST_NOT_FOUND;
                end else begin
                  res_valid <= 1'b0;
                  key       <= value;
                  scan_ptr  <= front;
                  issue_cnt <= '0;
                  cmp_idx   <= '0;
                  rd_valid  <= 1'b0;
                  state     <= bdqs_pkg::S_SCAN;
                end
              end
              default: begin
                res_valid <= 1'b1;
                status    <= bdqs_pkg::ST_OK;
                occupancy <= occ_bits(count);
              end
            endcase
          end
        end
        bdqs_pkg::S_SCAN: begin
          // issue the next read while comparing the previous one
          rd_valid <= mem_re;
          if (mem_re) begin
            scan_ptr  <= scan_inc;
            issue_cnt <= issue_cnt + CW'(1);
          end
          if (rd_valid) begin
            if (rd_data == key) begin
              res_valid <= 1'b1;
              status    <= bdqs_pkg::ST_OK;
              position  <= pos_bits(cmp_idx);
              state     <= bdqs_pkg::S_IDLE;
            end else if (cmp_idx == count - CW'(1)) begin
              res_valid <= 1'b1;
              status    <= bdqs_pkg::ST_NOT_FOUND;
              position  <= '0;
              state     <= bdqs_pkg::S_IDLE;
            end else begin
              cmp_idx <= cmp_idx + CW'(1);
            end
          end
        end
        default: begin
          state <= bdqs_pkg::S_IDLE;
        end
      endcase
    end
  end

  // occupancy and ring pointer stay in range
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count <= FULL) && (front <= LAST))
    else $error("entry count or front pointer out of range");

  // the result register stays empty while a search is running
  a_scan_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == bdqs_pkg::S_SCAN) |-> !res_valid)
    else $error("result pending during search");

  // scan never reads past the stored entries
  a_scan_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == bdqs_pkg::S_SCAN) |-> ((issue_cnt <= count) && (cmp_idx < count)))
    else $error("search index beyond occupancy");

  // a rejected push leaves the store full
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (req_fire && is_push && (count == FULL)) |=> (count == FULL))
    else $error("push into full store changed occupancy");

  // a request is taken only with an empty or draining result register
  a_accept_slot: assert property (@(posedge clk) disable iff (rst)
    req_fire |-> (!res_valid || !res_stall))
    else $error("request taken while result blocked");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int TIMEOUT_NS = 1_000_000;
  localparam int IDLE_PERCENT = 9;

  // codes the block treats as no operation
  localparam logic [2:0] MODE_FIRST_UNUSED = bdqs_pkg::MODE_SEARCH + 3'd1;
  localparam logic [2:0] MODE_LAST_UNUSED  = 3'd7;

  // leaning of the random request mix
  typedef enum int {LEAN_EVEN, LEAN_FILL, LEAN_DRAIN} lean_t;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] key;
    logic [1:0]         status;
    logic [3:0]         position;
    logic [4:0]         occupancy;
  } deque_result_t;

  // tracks the deque contents and the results still owed by the block
  class deque_tracker;
    logic signed [31:0] ring [DEPTH];
    int head;
    int count;
    int mismatches;
    deque_result_t owed [$];

    function new();
      head = 0;
      count = 0;
      mismatches = 0;
    endfunction

    function int outstanding();
      return owed.size();
    endfunction

    // apply one accepted request and queue the result it must give
    function void note_request(logic [2:0] op, logic signed [31:0] key);
      deque_result_t r;
      bit hit;
      int i;
      r.op = op;
      r.key = key;
      r.status = bdqs_pkg::ST_OK;
      r.position = '0;
      hit = 0;
      case (op)
        bdqs_pkg::MODE_PUSH_FRONT: begin
          if (count >= DEPTH) begin
            r.status = bdqs_pkg::ST_FULL;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = key;
            count++;
          end
        end
        bdqs_pkg::MODE_PUSH_BACK: begin
          if (count >= DEPTH) begin
            r.status = bdqs_pkg::ST_FULL;
          end else begin
            ring[(head + count) % DEPTH] = key;
            count++;
          end
        end
        bdqs_pkg::MODE_POP_FRONT: begin
          if (count == 0) begin
            r.status = bdqs_pkg::ST_EMPTY;
          end else begin
            head = (head + 1) % DEPTH;
            count--;
          end
        end
        bdqs_pkg::MODE_POP_BACK: begin
          if (count == 0) begin
            r.status = bdqs_pkg::ST_EMPTY;
          end else begin
            count--;
          end
        end
        bdqs_pkg::MODE_SEARCH: begin
          r.status = bdqs_pkg::ST_NOT_FOUND;
          for (i = 0; i < count && !hit; i++) begin
            if (ring[(head + i) % DEPTH] == key) begin
              hit = 1;
              r.status = bdqs_pkg::ST_OK;
              r.position = i[3:0];
            end
          end
        end
        default: begin
        end
      endcase
      r.occupancy = count[4:0];
      owed.push_back(r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] result mismatch: %s", $realtime, what);
    endtask

    // compare one drained result against the oldest owed one
    task check_result(logic [1:0] st, logic [3:0] pos, logic [4:0] occ);
      deque_result_t e;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d position %0d occupancy %0d",
                                  st, pos, occ));
      end else begin
        e = owed.pop_front();
        if (st !== e.status)
          report_mismatch($sformatf("op %0d key %h status %0d, want %0d",
                                    e.op, e.key, st, e.status));
        if (pos !== e.position)
          report_mismatch($sformatf("op %0d key %h position %0d, want %0d",
                                    e.op, e.key, pos, e.position));
        if (occ !== e.occupancy)
          report_mismatch($sformatf("op %0d key %h occupancy %0d, want %0d",
                                    e.op, e.key, occ, e.occupancy));
      end
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  logic [2:0]         mode;
  logic signed [31:0] value;
  logic               res_valid;
  logic               res_stall;
  logic [1:0]         status;
  logic [3:0]         position;
  logic [4:0]         occupancy;

  bit calm;
  bit hold_results;
  deque_tracker tracker = new();

  logic signed [31:0] value_pool [8] = '{
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
    32'sh0000_0001, 32'sh5A5A_5A5A, 32'shA5A5_A5A5, 32'sh0001_0000
  };

  bounded_deque_with_search_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .mode     (mode),
    .value    (value),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .status   (status),
    .position (position),
    .occupancy(occupancy)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // offer one request, with random idle cycles ahead of it, until taken
  task automatic send_request(input logic [2:0] op, input logic signed [31:0] key);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    mode      <= op;
    value     <= key;
    do @(posedge clk); while (req_stall);
    tracker.note_request(op, key);
  endtask

  // stop offering and wait for every owed result
  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // values half the time from a small pool so searches hit
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 1))
      return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_mode(lean_t lean);
    int r;
    int push_share;
    int pop_share;
    r = $urandom_range(0, 99);
    case (lean)
      LEAN_FILL:  begin push_share = 55; pop_share = 15; end
      LEAN_DRAIN: begin push_share = 15; pop_share = 55; end
      default:    begin push_share = 35; pop_share = 35; end
    endcase
    if (r < push_share)
      return $urandom_range(0, 1) ? bdqs_pkg::MODE_PUSH_BACK : bdqs_pkg::MODE_PUSH_FRONT;
    if (r < push_share + pop_share)
      return $urandom_range(0, 1) ? bdqs_pkg::MODE_POP_BACK : bdqs_pkg::MODE_POP_FRONT;
    if (r < 97)
      return bdqs_pkg::MODE_SEARCH;
    return 3'($urandom_range(MODE_LAST_UNUSED, MODE_FIRST_UNUSED));
  endfunction

  // result side stall, with one long hold-off on request
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_results = 1'b0;
      end else begin
        res_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && !res_stall)
      tracker.check_result(status, position, occupancy);
  end

  // stimulus
  initial begin
    int i;
    int n;
    lean_t lean;
    rst       = 1'b1;
    req_valid = 1'b0;
    mode      = bdqs_pkg::MODE_PUSH_FRONT;
    value     = '0;
    calm      = 1'b0;
    hold_results = 1'b0;
    lean      = LEAN_EVEN;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty store corner cases and unused code
    send_request(bdqs_pkg::MODE_POP_FRONT, 32'sh0000_0000);
    send_request(bdqs_pkg::MODE_POP_BACK, 32'shFFFF_FFFF);
    send_request(bdqs_pkg::MODE_SEARCH, 32'shFFFF_FFFF);
    send_request(MODE_FIRST_UNUSED, 32'shFFFF_FFFF);
    // single remaining entry popped from either end
    send_request(bdqs_pkg::MODE_PUSH_BACK, 32'sh7FFF_FFFF);
    send_request(bdqs_pkg::MODE_POP_FRONT, 32'sh7FFF_FFFF);
    send_request(bdqs_pkg::MODE_PUSH_FRONT, 32'sh8000_0000);
    send_request(bdqs_pkg::MODE_POP_BACK, 32'sh8000_0000);
    // fill to the top from both ends
    for (i = 0; i < DEPTH; i++)
      send_request(i[0] ? bdqs_pkg::MODE_PUSH_BACK : bdqs_pkg::MODE_PUSH_FRONT,
                   i < 8 ? value_pool[i] : 32'sh3C00_0000 + i);
    // push when full, searches at both ends, unused code when full
    send_request(bdqs_pkg::MODE_PUSH_FRONT, 32'sh1111_1111);
    send_request(bdqs_pkg::MODE_PUSH_BACK, 32'sh2222_2222);
    send_request(bdqs_pkg::MODE_SEARCH, 32'sh3C00_000F);
    send_request(bdqs_pkg::MODE_SEARCH, 32'sh3C00_000E);
    send_request(MODE_LAST_UNUSED, 32'sh0000_0000);

    // random requests with a drifting mix
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0)
        lean = lean_t'($urandom_range(0, 2));
      if (n == 400)
        hold_results = 1'b1;
      if (n == 900)
        drain_results();
      calm = (n >= 1200 && n < 1500);
      send_request(pick_mode(lean), pick_value());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
